[sv/kwm_pkg.sv]
// ============================================================================
// kwm_pkg
// Shared types and constants of the k-way merge min-heap: entry layout,
// widths derived from the heap depth, sequencer states and the RAM request.
// ============================================================================
package kwm_pkg;

    // Heap depth and the widths that follow from it.
    localparam int MAX_ENTRIES = 512;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    // A child index of the last entry can reach twice the depth.
    localparam int IDX_W       = $clog2(2 * MAX_ENTRIES + 1);

    // Field widths fixed by the interface.
    localparam int KEY_W       = 32;
    localparam int SRC_W       = 9;
    localparam int CAP_W       = 10;
    localparam int OUT_CNT_W   = 10;
    localparam int ENT_W       = KEY_W + SRC_W;

    // Width used to compare the count against the capacity register.
    localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);

    // Operation codes of the mode field.
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // One heap entry as stored in the RAM.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [SRC_W-1:0]        src;
    } entry_t;

    // Access request from the sequencer to the heap RAM.
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_UP,
        ST_EX_LOAD,
        ST_DOWN,
        ST_DONE
    } state_t;

endpackage

[sv/kwm_ram.sv]
// ============================================================================
// kwm_ram
// Generic synchronous RAM with one write port and two read ports.
// Read data is registered and appears in the cycle after the address.
// ============================================================================
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // Storage array and registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem_reg[rd_addr_a];
        rd_data_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[sv/kwm_ctrl.sv]
// ============================================================================
// kwm_ctrl
// Heap sequencer: accepts one operation, walks the heap one level per cycle
// through the RAM, and hands the result to an output register.
// ============================================================================
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CAP_W-1:0]        cap,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic signed [KEY_W-1:0] value,
    input  logic [SRC_W-1:0]        source,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [KEY_W-1:0] min_value,
    output logic [SRC_W-1:0]        min_source,
    output logic                    got_item,
    output logic                    was_dropped,
    output logic [OUT_CNT_W-1:0]    entries_after,
    output mem_req_t                mem_req,
    input  entry_t                  rd_data_a,
    input  entry_t                  rd_data_b
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    entry_t              x_reg, x_next;
    logic                mode_reg, mode_next;
    entry_t              res_entry_reg, res_entry_next;
    logic                res_got_reg, res_got_next;
    logic                res_drop_reg, res_drop_next;

    logic                out_valid_reg;
    entry_t              out_entry_reg;
    logic                out_got_reg;
    logic                out_drop_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic                heap_full;
    logic                out_load;
    logic [ADDR_W-1:0]   parent_idx;
    logic                up_move;
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic                left_win;
    entry_t              best_lr;
    logic                right_win;
    logic                down_move;
    logic [ADDR_W-1:0]   child_idx;
    entry_t              child_data;
    logic [IDX_W-1:0]    grand_left;
    logic [ADDR_W-1:0]   ins_parent;

    // The heap is full when the count reaches the register or the depth.
    assign heap_full = (LIM_W'(count_reg) >= LIM_W'(cap)) ||
                       (LIM_W'(count_reg) >= LIM_W'(MAX_ENTRIES));

    // The result moves to the output register when that register is free.
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Sift up: the moving entry rises while it is strictly less than its parent.
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign up_move    = (pos_reg != '0) && ($signed(x_reg.key) < $signed(rd_data_a.key));
    assign ins_parent = (ADDR_W'(count_reg) - ADDR_W'(1)) >> 1;

    // Sift down: left child first, then right against the smaller so far.
    assign left_idx   = (IDX_W'(pos_reg) << 1) + IDX_W'(1);
    assign right_idx  = left_idx + IDX_W'(1);
    assign left_win   = (left_idx < IDX_W'(count_reg)) &&
                        ($signed(rd_data_a.key) < $signed(x_reg.key));
    assign best_lr    = left_win ? rd_data_a : x_reg;
    assign right_win  = (right_idx < IDX_W'(count_reg)) &&
                        ($signed(rd_data_b.key) < $signed(best_lr.key));
    assign down_move  = left_win || right_win;
    assign child_idx  = right_win ? ADDR_W'(right_idx) : ADDR_W'(left_idx);
    assign child_data = right_win ? rd_data_b : rd_data_a;
    assign grand_left = (IDX_W'(child_idx) << 1) + IDX_W'(1);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    state_next = heap_full ? ST_DONE : ST_UP;
                end
                else
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_EX_LOAD;
                end
            end
            ST_UP:
            begin
                if (!up_move)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EX_LOAD:
            begin
                state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_DOWN;
            end
            ST_DOWN:
            begin
                if (!down_move)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM access for each state.
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        mode_next      = mode_reg;
        res_entry_next = res_entry_reg;
        res_got_next   = res_got_reg;
        res_drop_next  = res_drop_reg;
        mem_req        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    x_next.key = value;
                    x_next.src = source;
                end
            end
            ST_START:
            begin
                res_entry_next = '0;
                res_got_next   = 1'b0;
                res_drop_next  = 1'b0;
                if (mode_reg == MODE_INSERT)
                begin
                    if (heap_full)
                    begin
                        res_drop_next = 1'b1;
                    end
                    else
                    begin
                        // The new entry starts at the end of the heap.
                        pos_next          = ADDR_W'(count_reg);
                        count_next        = count_reg + CNT_W'(1);
                        mem_req.rd_addr_a = ins_parent;
                    end
                end
                else if (count_reg != '0)
                begin
                    // Fetch the root and the last entry together.
                    mem_req.rd_addr_a = '0;
                    mem_req.rd_addr_b = ADDR_W'(count_reg - CNT_W'(1));
                end
            end
            ST_UP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                if (up_move)
                begin
                    // The parent drops into the hole; look at the next parent.
                    mem_req.wr_data   = rd_data_a;
                    pos_next          = parent_idx;
                    mem_req.rd_addr_a = (parent_idx - ADDR_W'(1)) >> 1;
                end
                else
                begin
                    mem_req.wr_data = x_reg;
                end
            end
            ST_EX_LOAD:
            begin
                res_entry_next    = rd_data_a;
                res_got_next      = 1'b1;
                count_next        = count_reg - CNT_W'(1);
                x_next            = rd_data_b;
                pos_next          = '0;
                mem_req.rd_addr_a = ADDR_W'(1);
                mem_req.rd_addr_b = ADDR_W'(2);
            end
            ST_DOWN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                if (down_move)
                begin
                    // The smaller child rises into the hole; fetch its children.
                    mem_req.wr_data   = child_data;
                    pos_next          = child_idx;
                    mem_req.rd_addr_a = ADDR_W'(grand_left);
                    mem_req.rd_addr_b = ADDR_W'(grand_left + IDX_W'(1));
                end
                else
                begin
                    mem_req.wr_data = x_reg;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        x_reg         <= x_next;
        mode_reg      <= mode_next;
        res_entry_reg <= res_entry_next;
        res_got_reg   <= res_got_next;
        res_drop_reg  <= res_drop_next;
    end

    // Output register: holds a finished result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_entry_reg <= res_entry_reg;
            out_got_reg   <= res_got_reg;
            out_drop_reg  <= res_drop_reg;
            out_count_reg <= count_reg;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign min_value     = out_entry_reg.key;
    assign min_source    = out_entry_reg.src;
    assign got_item      = out_got_reg;
    assign was_dropped   = out_drop_reg;
    assign entries_after = OUT_CNT_W'(out_count_reg);

endmodule

[sv/k_way_merge_min_heap_core.sv]
// ============================================================================
// k_way_merge_min_heap_core
// Binary min-heap of (key, source list) entries for k-way merging.
// ============================================================================
// One operation is in flight at a time. An insert passes through the start
// state, the rise state once per level it rises and once more for the final
// write, and the done state; an extract through the start state, a load state
// that takes the root, the sink state once per level the moved entry sinks and
// once more for the final write, and the done state. A dropped insert and an
// extract on an empty heap go from the start state straight to the done state,
// and an extract of the last entry skips the sink state. The pace is set by the
// heap RAM: each level needs one registered read, compared and written back in
// the following cycle while the next level's read is issued. Every operation
// returns exactly one result. The sequencer takes the next transfer in the cycle
// after its result reaches the output register, so a result waiting there does
// not block the next operation; that operation's own result waits in the sequencer until the output register is free.
// ============================================================================
module k_way_merge_min_heap_core
    import kwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CAP_W-1:0]        capacity_limit,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic signed [KEY_W-1:0] value,
    input  logic [SRC_W-1:0]        source,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [KEY_W-1:0] min_value,
    output logic [SRC_W-1:0]        min_source,
    output logic                    got_item,
    output logic                    was_dropped,
    output logic [OUT_CNT_W-1:0]    entries_after
);

    logic [CAP_W-1:0] cap_reg;
    mem_req_t         mem_req;
    logic [ENT_W-1:0] ram_rd_a;
    logic [ENT_W-1:0] ram_rd_b;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= capacity_limit;
        end
    end

    // Heap storage: key and source list side by side.
    kwm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk       (clk),
        .wr_en     (mem_req.wr_en),
        .wr_addr   (mem_req.wr_addr),
        .wr_data   (mem_req.wr_data),
        .rd_addr_a (mem_req.rd_addr_a),
        .rd_data_a (ram_rd_a),
        .rd_addr_b (mem_req.rd_addr_b),
        .rd_data_b (ram_rd_b)
    );

    // Sequencer.
    kwm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cap           (cap_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .source        (source),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .min_value     (min_value),
        .min_source    (min_source),
        .got_item      (got_item),
        .was_dropped   (was_dropped),
        .entries_after (entries_after),
        .mem_req       (mem_req),
        .rd_data_a     (entry_t'(ram_rd_a)),
        .rd_data_b     (entry_t'(ram_rd_b))
    );

endmodule

[test/kwm_heap_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// kwm_heap_checker
// Watches both channels of the k-way merge min-heap and checks every result.
// It keeps its own min-heap and capacity copy, updated on each input transfer
// and capacity write, and compares each output transfer field by field with
// the oldest predicted result.
// ============================================================================
module kwm_heap_checker
    import kwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CAP_W-1:0]        capacity_limit,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    mode,
    input  logic signed [KEY_W-1:0] value,
    input  logic [SRC_W-1:0]        source,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [KEY_W-1:0] min_value,
    input  logic [SRC_W-1:0]        min_source,
    input  logic                    got_item,
    input  logic                    was_dropped,
    input  logic [OUT_CNT_W-1:0]    entries_after,
    output int                      outstanding,
    output int                      error_count
);

    typedef struct packed {
        logic signed [KEY_W-1:0] min_value;
        logic [SRC_W-1:0]        min_source;
        logic                    got_item;
        logic                    was_dropped;
        logic [OUT_CNT_W-1:0]    entries_after;
    } heap_result_t;

    // Shadow heap, entry count and capacity register.
    entry_t           heap_mem [MAX_ENTRIES];
    int               held_count;
    logic [CAP_W-1:0] cap_reg;
    heap_result_t     heap_result_q [$];
    int               fail_tally = 0;

    assign error_count = fail_tally;

    function automatic void swap_entries(input int a, input int b);
        entry_t tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endfunction

    // Applies one operation to the shadow heap and returns its result.
    function automatic heap_result_t model_heap_op(input logic op,
                                                   input logic signed [KEY_W-1:0] key,
                                                   input logic [SRC_W-1:0] src);
        heap_result_t res;
        int           limit;
        int           pos;
        int           parent;
        int           best;
        int           lft;
        int           rgt;
        bit           sinking;
        res   = '0;
        limit = (int'(cap_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
        if (op == MODE_INSERT)
        begin
            if (held_count >= limit)
            begin
                res.was_dropped = 1'b1;
            end
            else
            begin
                heap_mem[held_count].key = key;
                heap_mem[held_count].src = src;
                pos = held_count;
                held_count++;
                // Rise while strictly smaller than the parent.
                while (pos > 0 && heap_mem[pos].key < heap_mem[(pos - 1) / 2].key)
                begin
                    parent = (pos - 1) / 2;
                    swap_entries(pos, parent);
                    pos = parent;
                end
            end
        end
        else if (held_count > 0)
        begin
            res.min_value  = heap_mem[0].key;
            res.min_source = heap_mem[0].src;
            res.got_item   = 1'b1;
            held_count--;
            if (held_count > 0)
            begin
                heap_mem[0] = heap_mem[held_count];
                pos         = 0;
                sinking     = 1'b1;
                // Sink: left child is tried first, then right, strict less-than.
                while (sinking)
                begin
                    best = pos;
                    lft  = 2 * pos + 1;
                    rgt  = 2 * pos + 2;
                    if (lft < held_count && heap_mem[lft].key < heap_mem[best].key)
                        best = lft;
                    if (rgt < held_count && heap_mem[rgt].key < heap_mem[best].key)
                        best = rgt;
                    if (best == pos)
                    begin
                        sinking = 1'b0;
                    end
                    else
                    begin
                        swap_entries(best, pos);
                        pos = best;
                    end
                end
            end
        end
        res.entries_after = OUT_CNT_W'(held_count);
        return res;
    endfunction

    task automatic report_field(input string field, input longint want, input longint seen);
        fail_tally++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
    endtask

    // Compare output transfers first, then fold in this edge's capacity write
    // and input transfer; an input taken at this edge cannot have its result yet.
    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        heap_result_t seen;
        if (!rst_n)
        begin
            held_count  = 0;
            cap_reg     = CAP_RESET;
            heap_result_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{min_value, min_source, got_item, was_dropped, entries_after};
                if (heap_result_q.size() == 0)
                begin
                    fail_tally++;
                    $error("result transfer with no result expected");
                end
                else
                begin
                    want = heap_result_q.pop_front();
                    if (seen.min_value !== want.min_value)
                        report_field("min_value", want.min_value, seen.min_value);
                    if (seen.min_source !== want.min_source)
                        report_field("min_source", want.min_source, seen.min_source);
                    if (seen.got_item !== want.got_item)
                        report_field("got_item", want.got_item, seen.got_item);
                    if (seen.was_dropped !== want.was_dropped)
                        report_field("was_dropped", want.was_dropped, seen.was_dropped);
                    if (seen.entries_after !== want.entries_after)
                        report_field("entries_after", want.entries_after,
                                     seen.entries_after);
                end
            end
            if (cfg_wr_en)
                cap_reg = capacity_limit;
            if (in_valid && !in_stall)
                heap_result_q.push_back(model_heap_op(mode, value, source));
            outstanding <= heap_result_q.size();
        end
    end

endmodule

[test/tb_k_way_merge_min_heap_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_k_way_merge_min_heap_core
// Regression for the k-way merge min-heap core.
// Directed inserts and extracts cover key extremes, equal keys, empty and
// full heaps and capacity changes; random phases then fill the heap to its
// depth, drain it, and run merge-like insert/extract sequences under random
// idling and a long output hold. A separate checker predicts and compares.
// ============================================================================
module tb_k_way_merge_min_heap_core;
    import kwm_pkg::*;

    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic [CAP_W-1:0]        capacity_limit = CAP_RESET;
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic                    mode           = MODE_INSERT;
    logic signed [KEY_W-1:0] value          = '0;
    logic [SRC_W-1:0]        source         = '0;
    logic                    out_valid;
    logic                    out_stall      = 1'b0;
    logic signed [KEY_W-1:0] min_value;
    logic [SRC_W-1:0]        min_source;
    logic                    got_item;
    logic                    was_dropped;
    logic [OUT_CNT_W-1:0]    entries_after;

    int   outstanding;
    int   error_count;
    int   cycle_count = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    logic rx_steady   = 1'b0;
    bit   tx_steady   = 1'b0;

    always #1 clk = ~clk;

    k_way_merge_min_heap_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .capacity_limit(capacity_limit),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .source        (source),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .min_value     (min_value),
        .min_source    (min_source),
        .got_item      (got_item),
        .was_dropped   (was_dropped),
        .entries_after (entries_after)
    );

    kwm_heap_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .capacity_limit(capacity_limit),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .source        (source),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .min_value     (min_value),
        .min_source    (min_source),
        .got_item      (got_item),
        .was_dropped   (was_dropped),
        .entries_after (entries_after),
        .outstanding   (outstanding),
        .error_count   (error_count)
    );

    // Result side: one long hold when requested, otherwise random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= !rx_steady && ($urandom_range(99) < 30);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("k_way_merge_min_heap_core regression: fail");
            $finish;
        end
    end

    // Key mix: full range, a narrow band that gives many equal keys, corners, small positive keys.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] corner_keys [4];
        corner_keys = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $signed(KEY_W'($urandom_range(15))) - 8;
            2:       return corner_keys[$urandom_range(3)];
            default: return KEY_W'($urandom_range(1000));
        endcase
    endfunction

    // Offers one item and returns once the transfer has happened. Valid stays
    // high on return so back-to-back items never drop it within a time step.
    task automatic offer_op(input logic op, input logic signed [KEY_W-1:0] key,
                            input logic [SRC_W-1:0] src);
        if (!tx_steady)
        begin
            while ($urandom_range(99) < 30)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        mode     <= op;
        value    <= key;
        source   <= src;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Capacity is written only with the core idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en      <= 1'b1;
        capacity_limit <= cap;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
    endtask

    task automatic run_mix(input int count, input int insert_pct);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < insert_pct)
                offer_op(MODE_INSERT, pick_key(), SRC_W'($urandom_range(511)));
            else
                offer_op(MODE_EXTRACT, pick_key(), SRC_W'($urandom_range(511)));
        end
    endtask

    // Merge-like use: load one head per list, then extract and refill, then drain.
    task automatic run_merge(input int lists, input int rounds);
        int i;
        set_capacity(CAP_W'(lists));
        for (i = 0; i < lists; i++)
            offer_op(MODE_INSERT, pick_key(), SRC_W'(i));
        for (i = 0; i < rounds; i++)
        begin
            offer_op(MODE_EXTRACT, pick_key(), SRC_W'($urandom_range(511)));
            if ($urandom_range(9) != 0)
                offer_op(MODE_INSERT, pick_key(), SRC_W'($urandom_range(lists - 1)));
        end
        for (i = 0; i <= lists; i++)
            offer_op(MODE_EXTRACT, '0, '0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty extract, key corners, equal keys in insertion order.
        offer_op(MODE_EXTRACT, '0, '0);
        offer_op(MODE_INSERT, 32'sh7FFF_FFFF, 9'd511);
        offer_op(MODE_INSERT, 32'sh8000_0000, 9'd0);
        offer_op(MODE_INSERT, 32'sh0, 9'd5);
        offer_op(MODE_INSERT, -32'sd1, 9'd6);
        offer_op(MODE_INSERT, 32'sd5, 9'd1);
        offer_op(MODE_INSERT, 32'sd5, 9'd2);
        offer_op(MODE_INSERT, 32'sd5, 9'd3);
        repeat (8) offer_op(MODE_EXTRACT, 32'sh7FFF_FFFF, 9'd511);

        // Zero capacity drops every insert.
        set_capacity(CAP_W'(0));
        offer_op(MODE_INSERT, 32'sd1, 9'd9);
        offer_op(MODE_EXTRACT, '0, '0);

        // Capacity lowered below the held count: inserts drop until it falls.
        set_capacity(CAP_W'(3));
        offer_op(MODE_INSERT, 32'sd10, 9'd4);
        offer_op(MODE_INSERT, 32'sd20, 9'd8);
        offer_op(MODE_INSERT, 32'sd30, 9'd16);
        set_capacity(CAP_W'(1));
        offer_op(MODE_INSERT, 32'sd40, 9'd32);
        offer_op(MODE_EXTRACT, '0, '0);
        offer_op(MODE_EXTRACT, '0, '0);
        offer_op(MODE_INSERT, 32'sd50, 9'd64);
        offer_op(MODE_EXTRACT, '0, '0);
        offer_op(MODE_INSERT, 32'sd60, 9'd128);
        offer_op(MODE_EXTRACT, '0, '0);

        // Fill to the full depth under an oversized capacity, with one long
        // output hold so the core backs up and stalls its input.
        set_capacity(CAP_W'(1023));
        hold_req <= 1'b1;
        run_mix(600, 95);

        // Full heap with a small capacity, then zero capacity.
        set_capacity(CAP_W'(5));
        run_mix(80, 50);
        set_capacity(CAP_W'(0));
        run_mix(30, 60);

        // Drain back to empty.
        set_capacity(CAP_W'(512));
        run_mix(540, 1);

        // Merge sequences; the larger ones run with no idling on either side.
        run_merge(1, 10);
        run_merge(2, 10);
        run_merge(3, 12);
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        run_merge(8, 15);
        run_merge(31, 20);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;

        // Random capacity and a random mix to close.
        set_capacity(CAP_W'($urandom_range(1, 40)));
        run_mix(40, 55);

        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("k_way_merge_min_heap_core regression: pass");
        else
            $display("k_way_merge_min_heap_core regression: fail");
        $finish;
    end

endmodule
